/* sv/oed_pkg.sv */
package oed_pkg;

    // Fixed field widths
    localparam int CH         = 3;
    localparam int SMP_W      = 8;
    localparam int SMP_MAX    = 255;
    localparam int ONSET_W    = 12;
    localparam int GAIN_W     = 4;
    localparam int MNE_W      = 21;
    localparam int NW_W       = 11;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Default structural sizes
    localparam int WINDOW_FRAMES_DEF = 64;
    localparam int MAX_FRAMES_DEF    = 2048;
    localparam int MID_DEPTH         = 4;
    localparam int RES_DEPTH         = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NWIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST   = 4'd6;
    localparam logic [MNE_W-1:0]  MIN_NE_RST = 21'd100;
    localparam logic [NW_W-1:0]   NWIN_RST   = 11'd512;
    localparam logic [SMP_W-1:0]  CENTER_RST = 8'd128;

    localparam logic [ONSET_W-1:0] ONSET_NONE = '1;

    typedef logic [CH-1:0][SMP_W-1:0] t_frame;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [MNE_W-1:0]  min_ne;
        logic [NW_W-1:0]   nwin;
        logic [SMP_W-1:0]  center;
    } t_cfg;

    // One classified frame handed from front to back
    typedef struct packed {
        logic               store;
        logic               sub;
        logic               eval;
        logic               last;
        logic [ONSET_W-1:0] start;
        t_frame             smp;
        t_frame             old;
    } t_work;

    // Control carried alongside each back-end stage
    typedef struct packed {
        logic               act;
        logic               last;
        logic               heard;
        logic [ONSET_W-1:0] start;
    } t_tag;

    typedef struct packed {
        logic [CH-1:0][ONSET_W-1:0] onset;
        logic                       all_heard;
    } t_result;

endpackage

/* sv/oed_fifo.sv */
module oed_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/oed_front.sv */
module oed_front import oed_pkg::*; #(
    parameter int WINDOW_FRAMES = WINDOW_FRAMES_DEF,
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_frame i_frame,
    input  logic   i_last,
    output logic   o_valid,
    output t_work  o_work,
    input  logic   i_stall
);

    localparam int AW   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int FC_W = $clog2(MAX_FRAMES + 1);

    t_frame          r_hist [WINDOW_FRAMES];
    t_frame          r_rdata;
    logic [FC_W-1:0] r_fcnt;
    logic [AW-1:0]   r_slot;
    logic            r_a_valid;
    t_work           r_a_work;

    logic            w_accept;
    logic            w_store;
    logic            w_eval;
    logic [FC_W-1:0] w_start;

    assign o_full   = r_a_valid && i_stall;
    assign w_accept = i_push && !o_full;
    assign w_store  = (r_fcnt < FC_W'(MAX_FRAMES));
    assign w_eval   = w_store && (r_fcnt >= FC_W'(WINDOW_FRAMES));
    assign w_start  = r_fcnt - FC_W'(WINDOW_FRAMES);

    // Frame history: write the new frame, read back the one it replaces
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_store) begin
                r_hist[r_slot] <= i_frame;
            end
            r_rdata <= r_hist[r_slot];
        end
    end

    // Frame counter and history slot, rewound at the end of a capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_slot <= '0;
        end else if (w_accept) begin
            if (i_last) begin
                r_fcnt <= '0;
                r_slot <= '0;
            end else if (w_store) begin
                r_fcnt <= r_fcnt + 1'b1;
                r_slot <= (r_slot == AW'(WINDOW_FRAMES - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    // Hold the classified frame until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (!i_stall) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_work.store <= w_store;
            r_a_work.sub   <= w_eval;
            r_a_work.eval  <= w_eval;
            r_a_work.last  <= i_last;
            r_a_work.start <= ONSET_W'(w_start);
            r_a_work.smp   <= i_frame;
            r_a_work.old   <= '0;
        end
    end

    // Merge the replaced frame into the transaction
    always_comb begin
        o_work     = r_a_work;
        o_work.old = r_rdata;
    end

    assign o_valid = r_a_valid;

endmodule

/* sv/oed_back.sv */
module oed_back import oed_pkg::*; #(
    parameter int WINDOW_FRAMES = WINDOW_FRAMES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_work   i_work,
    output logic    o_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_full
);

    localparam int S1_W   = $clog2(WINDOW_FRAMES * SMP_MAX + 1);
    localparam int S2_W   = $clog2(WINDOW_FRAMES * SMP_MAX * SMP_MAX + 1);
    localparam int CS_W   = S1_W + SMP_W;
    localparam int CC_W   = 2 * SMP_W;
    localparam int EW     = S2_W + 2;
    localparam int EN_W   = S2_W;
    localparam int TOT_W  = EN_W + CNT_W;
    localparam int LHS_W  = EN_W + CNT_W;
    localparam int FLR_W  = MNE_W + CNT_W;
    localparam int BASE_W = (TOT_W > FLR_W) ? TOT_W : FLR_W;
    localparam int RHS_W  = BASE_W + GAIN_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // Running window sums of raw samples and their squares
    logic [S1_W-1:0]    r_s1 [CH];
    logic [S2_W-1:0]    r_s2 [CH];
    // Noise floor and onsets of the current capture
    logic [TOT_W-1:0]   r_tot [CH];
    logic [CNT_W-1:0]   r_noise_cnt;
    logic [ONSET_W-1:0] r_onset [CH];

    logic               r_p1_valid;
    t_tag               r_p1_tag;
    logic [CS_W-1:0]    r_p1_cs1 [CH];
    logic [S2_W-1:0]    r_p1_s2 [CH];
    logic [CC_W-1:0]    r_p1_cc;

    logic               r_p2_valid;
    t_tag               r_p2_tag;
    logic [EN_W-1:0]    r_p2_en [CH];

    logic               r_p3_valid;
    t_tag               r_p3_tag;
    logic [EN_W-1:0]    r_p3_en [CH];
    logic [CNT_W-1:0]   r_p3_cnt;
    logic [TOT_W-1:0]   r_p3_tot [CH];

    logic               r_p4_valid;
    t_tag               r_p4_tag;
    logic [LHS_W-1:0]   r_p4_lhs [CH];
    logic [FLR_W-1:0]   r_p4_flr;
    logic [TOT_W-1:0]   r_p4_tot [CH];

    logic               r_p5_valid;
    t_tag               r_p5_tag;
    logic [LHS_W-1:0]   r_p5_lhs [CH];
    logic [RHS_W-1:0]   r_p5_rhs [CH];

    logic               w_adv;
    logic               w_noise;
    logic               w_cmp;
    logic               w_p5_done;
    logic [EW-1:0]      w_e [CH];
    logic [BASE_W-1:0]  w_base [CH];
    logic [ONSET_W-1:0] w_onset [CH];
    logic               w_all;

    // Whole back end moves together while the result queue has room
    assign w_adv     = !i_res_full;
    assign o_pop     = w_adv && i_valid;
    assign w_p5_done = w_adv && r_p5_valid && r_p5_tag.last;

    // Slide the window sums: add the new frame, drop the replaced one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH; c++) begin
                r_s1[c] <= '0;
                r_s2[c] <= '0;
            end
        end else if (o_pop) begin
            for (int c = 0; c < CH; c++) begin
                if (i_work.last) begin
                    r_s1[c] <= '0;
                    r_s2[c] <= '0;
                end else if (i_work.store) begin
                    r_s1[c] <= S1_W'(({1'b0, r_s1[c]} + (S1_W + 1)'(i_work.smp[c]))
                               - (i_work.sub ? (S1_W + 1)'(i_work.old[c]) : '0));
                    r_s2[c] <= S2_W'(({1'b0, r_s2[c]}
                               + (S2_W + 1)'(CC_W'(i_work.smp[c]) * CC_W'(i_work.smp[c])))
                               - (i_work.sub
                                  ? (S2_W + 1)'(CC_W'(i_work.old[c]) * CC_W'(i_work.old[c]))
                                  : '0));
                end
            end
        end
    end

    // Stage 1: center terms from the sums before this frame
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_tag.act   <= i_work.eval;
            r_p1_tag.last  <= i_work.last;
            r_p1_tag.heard <= 1'b0;
            r_p1_tag.start <= i_work.start;
            r_p1_cc        <= CC_W'(i_cfg.center) * CC_W'(i_cfg.center);
            for (int c = 0; c < CH; c++) begin
                r_p1_cs1[c] <= CS_W'(r_s1[c]) * CS_W'(i_cfg.center);
                r_p1_s2[c]  <= r_s2[c];
            end
        end
    end

    // Stage 2: window energy = sum x^2 - 2 c sum x + W c^2
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_e[c] = EW'(r_p1_s2[c]) + EW'(r_p1_cc) * EW'(WINDOW_FRAMES)
                   - (EW'(r_p1_cs1[c]) << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2_tag <= r_p1_tag;
            for (int c = 0; c < CH; c++) begin
                r_p2_en[c] <= EN_W'(w_e[c]);
            end
        end
    end

    // Stage 3: fold leading windows into the noise floor, pick out the rest
    assign w_noise = r_p2_valid && r_p2_tag.act
                  && (r_p2_tag.start < ONSET_W'(i_cfg.nwin));
    assign w_cmp   = r_p2_tag.act && !w_noise && (r_noise_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_cnt <= '0;
            for (int c = 0; c < CH; c++) begin
                r_tot[c] <= '0;
            end
        end else if (w_adv && r_p2_valid) begin
            if (r_p2_tag.last) begin
                r_noise_cnt <= '0;
                for (int c = 0; c < CH; c++) begin
                    r_tot[c] <= '0;
                end
            end else if (w_noise) begin
                r_noise_cnt <= r_noise_cnt + 1'b1;
                for (int c = 0; c < CH; c++) begin
                    r_tot[c] <= r_tot[c] + TOT_W'(r_p2_en[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p3_tag.act   <= w_cmp;
            r_p3_tag.last  <= r_p2_tag.last;
            r_p3_tag.heard <= w_noise || (r_noise_cnt != '0);
            r_p3_tag.start <= r_p2_tag.start;
            r_p3_cnt       <= r_noise_cnt;
            for (int c = 0; c < CH; c++) begin
                r_p3_en[c]  <= r_p2_en[c];
                r_p3_tot[c] <= r_tot[c];
            end
        end
    end

    // Stage 4: cross-multiply energy and floor by the window count
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p4_tag <= r_p3_tag;
            r_p4_flr <= FLR_W'(i_cfg.min_ne) * FLR_W'(r_p3_cnt);
            for (int c = 0; c < CH; c++) begin
                r_p4_lhs[c] <= LHS_W'(r_p3_en[c]) * LHS_W'(r_p3_cnt);
                r_p4_tot[c] <= r_p3_tot[c];
            end
        end
    end

    // Stage 5: raise the floor to its minimum, apply the gain
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_base[c] = (BASE_W'(r_p4_tot[c]) > BASE_W'(r_p4_flr))
                      ? BASE_W'(r_p4_tot[c]) : BASE_W'(r_p4_flr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p5_tag <= r_p4_tag;
            for (int c = 0; c < CH; c++) begin
                r_p5_lhs[c] <= r_p4_lhs[c];
                r_p5_rhs[c] <= RHS_W'(i_cfg.gain) * RHS_W'(w_base[c]);
            end
        end
    end

    // Compare, latch the first loud window, build the result
    always_comb begin
        w_all = r_p5_tag.heard;
        for (int c = 0; c < CH; c++) begin
            if ((r_onset[c] == ONSET_NONE) && r_p5_tag.act
                && (CMP_W'(r_p5_lhs[c]) > CMP_W'(r_p5_rhs[c]))) begin
                w_onset[c] = r_p5_tag.start;
            end else begin
                w_onset[c] = r_onset[c];
            end
            if (w_onset[c] == ONSET_NONE) begin
                w_all = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH; c++) begin
                r_onset[c] <= ONSET_NONE;
            end
        end else if (w_adv && r_p5_valid) begin
            for (int c = 0; c < CH; c++) begin
                r_onset[c] <= r_p5_tag.last ? ONSET_NONE : w_onset[c];
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
        end
    end

    assign o_res_valid = w_p5_done;
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            o_res.onset[c] = w_onset[c];
        end
        o_res.all_heard = w_all;
    end

    // A threshold test is only issued once noise has been measured
    a_cmp_needs_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p3_valid && r_p3_tag.act |-> r_p3_cnt != '0)
        else $error("threshold test issued without noise windows");

    // Onsets start over after a capture ends
    a_onset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p5_done |=> (r_onset[0] == ONSET_NONE) && (r_onset[1] == ONSET_NONE)
                      && (r_onset[2] == ONSET_NONE))
        else $error("onsets not cleared at end of capture");

    // A found onset on the first channel is never overwritten within a capture
    a_onset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_onset[0] != ONSET_NONE) && !w_p5_done |=> r_onset[0] == $past(r_onset[0]))
        else $error("found onset changed within capture");

endmodule

/* sv/multichannel_energy_onset_detector_core.sv */
// Channel   Direction  Handshake                 Payload
// frame     in         push / full               i_sample_mic1..3, i_last_frame
// result    out        empty / pop               o_onset_mic1..3, o_all_heard
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One frame is taken per cycle while full is low; a result passes the front register, the
// frame queue, five back stages and the result queue before it reaches the ports.
// Running sums of samples and squared samples make each frame one update of those sums.
// Reset (i_rst_n low, synchronous) restores register defaults and clears the capture.
// A held result freezes the back stages; the frame queue then fills and full rises.
// Configuration writes are always taken; the frame history needs no clearing sweep.
module multichannel_energy_onset_detector_core import oed_pkg::*; #(
    parameter int WINDOW_FRAMES = WINDOW_FRAMES_DEF,
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [SMP_W-1:0]          i_sample_mic1,
    input  logic [SMP_W-1:0]          i_sample_mic2,
    input  logic [SMP_W-1:0]          i_sample_mic3,
    input  logic                      i_last_frame,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [ONSET_W-1:0] o_onset_mic1,
    output logic signed [ONSET_W-1:0] o_onset_mic2,
    output logic signed [ONSET_W-1:0] o_onset_mic3,
    output logic                      o_all_heard,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_frame  w_frame;
    logic    w_front_valid;
    t_work   w_front_work;
    logic    w_mid_full;
    logic    w_mid_empty;
    t_work   w_mid_work;
    logic    w_mid_pop;
    logic    w_res_valid;
    t_result w_res;
    logic    w_res_full;
    t_result w_res_head;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= GAIN_RST;
            r_cfg.min_ne <= MIN_NE_RST;
            r_cfg.nwin   <= NWIN_RST;
            r_cfg.center <= CENTER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GAIN:   r_cfg.gain   <= i_cfg_data[GAIN_W-1:0];
                REG_MIN_NE: r_cfg.min_ne <= i_cfg_data[MNE_W-1:0];
                REG_NWIN:   r_cfg.nwin   <= i_cfg_data[NW_W-1:0];
                REG_CENTER: r_cfg.center <= i_cfg_data[SMP_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        w_frame[0] = i_sample_mic1;
        w_frame[1] = i_sample_mic2;
        w_frame[2] = i_sample_mic3;
    end

    oed_front #(
        .WINDOW_FRAMES(WINDOW_FRAMES),
        .MAX_FRAMES   (MAX_FRAMES)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_frame(w_frame),
        .i_last (i_last_frame),
        .o_valid(w_front_valid),
        .o_work (w_front_work),
        .i_stall(w_mid_full)
    );

    // Queue between front and back
    oed_fifo #(
        .WIDTH($bits(t_work)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_front_valid),
        .i_data (w_front_work),
        .o_full (w_mid_full),
        .i_pop  (w_mid_pop),
        .o_data (w_mid_work),
        .o_empty(w_mid_empty)
    );

    oed_back #(
        .WINDOW_FRAMES(WINDOW_FRAMES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (!w_mid_empty),
        .i_work     (w_mid_work),
        .o_pop      (w_mid_pop),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    // Result queue
    oed_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_valid),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_head),
        .o_empty(empty)
    );

    assign o_onset_mic1 = w_res_head.onset[0];
    assign o_onset_mic2 = w_res_head.onset[1];
    assign o_onset_mic3 = w_res_head.onset[2];
    assign o_all_heard  = w_res_head.all_heard;

endmodule

/* dv/multichannel_energy_onset_detector_core_test.sv */
module multichannel_energy_onset_detector_core_test;
    import oed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN           = WINDOW_FRAMES_DEF;
    localparam int FRAME_LIMIT   = MAX_FRAMES_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int RX_HOLD       = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEM_TARGET   = 850;
    localparam int RESULT_TARGET = 40;
    localparam int FIXED_PHASES  = 6;

    localparam t_result NO_ONSET = {{CH{ONSET_NONE}}, 1'b0};

    typedef struct {
        logic [SMP_W-1:0] mic1;
        logic [SMP_W-1:0] mic2;
        logic [SMP_W-1:0] mic3;
        logic             last;
        bit               typed;
        t_result          want;
    } t_stim_row;

    typedef struct {
        int unsigned gain;
        int unsigned min_ne;
        int unsigned nwin;
        int unsigned center;
        int unsigned captures;
        bit          brief;
        bit          squeeze;
    } t_phase;

    // Short captures: none of them reaches a full window, so no onset anywhere
    t_stim_row dir_rows [12] = '{
        '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, NO_ONSET},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, NO_ONSET},
        '{8'h00, 8'hFF, 8'h80, 1'b0, 1'b0, NO_ONSET},
        '{8'hFF, 8'h00, 8'h7F, 1'b0, 1'b0, NO_ONSET},
        '{8'h80, 8'h80, 8'h80, 1'b1, 1'b1, NO_ONSET},
        '{8'hAA, 8'h55, 8'h01, 1'b0, 1'b0, NO_ONSET},
        '{8'h55, 8'hAA, 8'hFE, 1'b0, 1'b0, NO_ONSET},
        '{8'h0F, 8'hF0, 8'h33, 1'b0, 1'b0, NO_ONSET},
        '{8'hF0, 8'h0F, 8'hCC, 1'b1, 1'b1, NO_ONSET},
        '{8'h01, 8'h02, 8'h04, 1'b1, 1'b1, NO_ONSET},
        '{8'h08, 8'h10, 8'h20, 1'b0, 1'b0, NO_ONSET},
        '{8'h40, 8'h80, 8'hFF, 1'b1, 1'b1, NO_ONSET}
    };

    // Register settings walked before the random settings take over
    t_phase fixed_phases [FIXED_PHASES] = '{
        '{6,  100,     4,    128, 3,  1'b0, 1'b0},
        '{15, 0,       1,    0,   2,  1'b0, 1'b0},
        '{0,  1048576, 8,    255, 2,  1'b0, 1'b0},
        '{1,  2097151, 0,    200, 2,  1'b0, 1'b0},
        '{6,  100,     2047, 128, 2,  1'b1, 1'b0},
        '{3,  50,      1024, 100, 40, 1'b1, 1'b1}
    };

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      push         = 1'b0;
    logic                      full;
    logic [SMP_W-1:0]          i_sample_mic1 = '0;
    logic [SMP_W-1:0]          i_sample_mic2 = '0;
    logic [SMP_W-1:0]          i_sample_mic3 = '0;
    logic                      i_last_frame = 1'b0;
    logic                      empty;
    logic                      pop          = 1'b0;
    logic signed [ONSET_W-1:0] o_onset_mic1;
    logic signed [ONSET_W-1:0] o_onset_mic2;
    logic signed [ONSET_W-1:0] o_onset_mic3;
    logic                      o_all_heard;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data   = '0;

    // Predictor copy of the registers and the capture state
    logic [GAIN_W-1:0] cfg_gain   = GAIN_RST;
    logic [MNE_W-1:0]  cfg_min_ne = MIN_NE_RST;
    logic [NW_W-1:0]   cfg_nwin   = NWIN_RST;
    logic [SMP_W-1:0]  cfg_center = CENTER_RST;

    logic [SMP_W-1:0]  hist [WIN][CH];
    longint unsigned   win_energy [CH];
    longint unsigned   noise_total [CH] = '{0, 0, 0};
    int unsigned       noise_count = 0;
    int unsigned       frame_count = 0;
    int                onset_at [CH] = '{-1, -1, -1};

    t_result           pending_onsets [$];
    int unsigned       frames_sent  = 0;
    int unsigned       results_due  = 0;
    int unsigned       mismatches   = 0;
    int unsigned       stall_cycles = 0;
    bit                tx_gaps      = 1'b1;
    bit                rx_gaps      = 1'b1;
    bit                hold_req     = 1'b0;

    multichannel_energy_onset_detector_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample_mic1 (i_sample_mic1),
        .i_sample_mic2 (i_sample_mic2),
        .i_sample_mic3 (i_sample_mic3),
        .i_last_frame  (i_last_frame),
        .empty         (empty),
        .pop           (pop),
        .o_onset_mic1  (o_onset_mic1),
        .o_onset_mic2  (o_onset_mic2),
        .o_onset_mic3  (o_onset_mic3),
        .o_all_heard   (o_all_heard),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Score the window starting at frame start: noise floor or onset search
    function automatic void score_window(input int unsigned start);
        longint unsigned e;
        longint unsigned floor_sum;
        longint unsigned base;
        int              d;
        for (int c = 0; c < CH; c++) begin
            e = 0;
            for (int k = 0; k < WIN; k++) begin
                d = int'(hist[k][c]) - int'(cfg_center);
                e += longint'(d * d);
            end
            win_energy[c] = e;
        end
        if (start < cfg_nwin) begin
            for (int c = 0; c < CH; c++) noise_total[c] += win_energy[c];
            noise_count++;
            return;
        end
        if (noise_count == 0) return;
        for (int c = 0; c < CH; c++) begin
            floor_sum = longint'(cfg_min_ne) * noise_count;
            base = (noise_total[c] < floor_sum) ? floor_sum : noise_total[c];
            if (onset_at[c] == -1 &&
                    win_energy[c] * noise_count > longint'(cfg_gain) * base) begin
                onset_at[c] = int'(start);
            end
        end
    endfunction

    // Advance the capture by one frame; return 1 with the result on a last frame
    function automatic bit onset_predict(input logic [SMP_W-1:0] s1, s2, s3,
                                         input logic last, output t_result res);
        int unsigned f;
        f = frame_count;
        res = '0;
        if (f < FRAME_LIMIT) begin
            if (f >= WIN) score_window(f - WIN);
            hist[f % WIN][0] = s1;
            hist[f % WIN][1] = s2;
            hist[f % WIN][2] = s3;
            frame_count = f + 1;
        end
        if (!last) return 1'b0;
        res.all_heard = (noise_count > 0);
        for (int c = 0; c < CH; c++) begin
            if (onset_at[c] == -1) res.all_heard = 1'b0;
            res.onset[c] = onset_at[c][ONSET_W-1:0];
        end
        // Clear the capture, keep the registers
        for (int c = 0; c < CH; c++) begin
            win_energy[c] = 0;
            noise_total[c] = 0;
            onset_at[c] = -1;
        end
        noise_count = 0;
        frame_count = 0;
        return 1'b1;
    endfunction

    // Offer one frame and record its expectation once taken
    task automatic send_frame(input logic [SMP_W-1:0] s1, s2, s3, input logic last,
                              input bit typed, input t_result typed_res);
        int unsigned gap;
        t_result     res;
        gap = tx_gaps ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_sample_mic1 <= s1;
        i_sample_mic2 <= s2;
        i_sample_mic3 <= s3;
        i_last_frame  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        frames_sent++;
        if (onset_predict(s1, s2, s3, last, res)) begin
            pending_onsets.push_back(typed ? typed_res : res);
            results_due++;
        end
    endtask

    // Drop push, drain every expected result, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        while (pending_onsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GAIN:   cfg_gain   = val[GAIN_W-1:0];
            REG_MIN_NE: cfg_min_ne = val[MNE_W-1:0];
            REG_NWIN:   cfg_nwin   = val[NW_W-1:0];
            REG_CENTER: cfg_center = val[SMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input int unsigned gain, min_ne, nwin, center);
        put_reg(REG_GAIN, CFG_DATA_W'(gain));
        put_reg(REG_MIN_NE, CFG_DATA_W'(min_ne));
        put_reg(REG_NWIN, CFG_DATA_W'(nwin));
        put_reg(REG_CENTER, CFG_DATA_W'(center));
        i_cfg_valid <= 1'b0;
    endtask

    // One capture: quiet around the center, each channel turning loud at its frame
    task automatic send_capture(input int len, input int quiet_amp, input int loud_amp,
                                input int loud_at [CH], input int split_at);
        logic [SMP_W-1:0] s [CH];
        int               amp;
        int               v;
        for (int f = 0; f < len; f++) begin
            if (f == split_at) begin
                settle();
                write_config(cfg_gain, cfg_min_ne, cfg_nwin, $urandom_range(0, 255));
            end
            for (int c = 0; c < CH; c++) begin
                amp = (f >= loud_at[c]) ? loud_amp : quiet_amp;
                v = int'(cfg_center) + int'($urandom_range(0, 2 * amp)) - amp;
                s[c] = (v < 0) ? '0 : (v > SMP_MAX) ? SMP_W'(SMP_MAX) : SMP_W'(v);
            end
            send_frame(s[0], s[1], s[2], f == len - 1, 1'b0, NO_ONSET);
        end
    endtask

    // Result side: random gaps, one long hold on request, compare each transaction
    initial begin : result_drain
        int unsigned gap;
        t_result     got;
        t_result     want;
        forever begin
            gap = rx_gaps ? $urandom_range(0, 18) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end else if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty && !hold_req) @(posedge i_clk);
            if (!empty) begin
                got.onset[0]  = o_onset_mic1;
                got.onset[1]  = o_onset_mic2;
                got.onset[2]  = o_onset_mic3;
                got.all_heard = o_all_heard;
                if (pending_onsets.size() == 0) begin
                    $display("%0t: unexpected result onsets %0d %0d %0d heard %0b", $time,
                             o_onset_mic1, o_onset_mic2, o_onset_mic3, o_all_heard);
                    mismatches++;
                end else begin
                    want = pending_onsets.pop_front();
                    for (int c = 0; c < CH; c++) begin
                        if (got.onset[c] !== want.onset[c]) begin
                            $display("%0t: mic%0d onset expected %0d got %0d", $time, c + 1,
                                     $signed(want.onset[c]), $signed(got.onset[c]));
                            mismatches++;
                        end
                    end
                    if (got.all_heard !== want.all_heard) begin
                        $display("%0t: all_heard expected %0b got %0b", $time,
                                 want.all_heard, got.all_heard);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : frame_source
        t_phase ph;
        int     len;
        int     eff_nwin;
        int     loud_at [CH];
        bit     full_len;
        bit     noisy;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset register values
        foreach (dir_rows[r]) begin
            send_frame(dir_rows[r].mic1, dir_rows[r].mic2, dir_rows[r].mic3,
                       dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < FIXED_PHASES || frames_sent < ITEM_TARGET ||
                        results_due < RESULT_TARGET; p++) begin
            if (p < FIXED_PHASES) begin
                ph = fixed_phases[p];
            end else begin
                ph.gain     = $urandom_range(0, 15);
                ph.min_ne   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2097151)
                                                          : $urandom_range(0, 400);
                ph.nwin     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                          : $urandom_range(0, 12);
                ph.center   = $urandom_range(0, 255);
                ph.captures = $urandom_range(1, 3);
                ph.brief    = 1'b0;
                ph.squeeze  = 1'b0;
            end
            settle();
            write_config(ph.gain, ph.min_ne, ph.nwin, ph.center);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            // Hold the result side while frames keep coming, so the input backs up
            if (ph.squeeze) begin
                tx_gaps  = 1'b0;
                hold_req = 1'b1;
            end
            eff_nwin = (cfg_nwin > 200) ? 40 : int'(cfg_nwin);
            for (int k = 0; k < ph.captures; k++) begin
                full_len = (p == 0 && k == 0) || (!ph.brief && $urandom_range(0, 1) == 1);
                if (ph.squeeze) len = $urandom_range(1, 3);
                else if (full_len) len = WIN + eff_nwin + $urandom_range(1, 60);
                else len = $urandom_range(1, 70);
                foreach (loud_at[c]) begin
                    loud_at[c] = ($urandom_range(0, 3) == 0) ? len
                                 : WIN + eff_nwin + $urandom_range(0, 40);
                end
                noisy = ($urandom_range(0, 4) == 0);
                send_capture(len, noisy ? 128 : $urandom_range(0, 3), $urandom_range(10, 127),
                             loud_at, (p == 0 && k == 0) ? len / 2 : -1);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/oed_pkg.sv
sv/oed_fifo.sv
sv/oed_front.sv
sv/oed_back.sv
sv/multichannel_energy_onset_detector_core.sv
dv/multichannel_energy_onset_detector_core_test.sv
